@@ rtl/ats_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_pkg
// Shared sizes, codes and state types for the aging task scheduler.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int NUM_CORES = 4;
  localparam int IDLE_BITS = 16;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int CUR_W  = SLOT_W + 1;

  localparam int FUNC_W   = 2;
  localparam int CORE_F_W = 2;
  localparam int TASK_F_W = 4;
  localparam int ENTRY_W  = 64;
  localparam int STATUS_W = 3;

  // Core pointer value that names no slot
  localparam logic [CUR_W-1:0] CUR_NONE = '1;

  typedef enum logic [FUNC_W-1:0] {
    F_TICK   = 2'd0,
    F_CREATE = 2'd1,
    F_EXIT   = 2'd2,
    F_NOP    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_FRESH   = 3'd0,
    RS_RESUME  = 3'd1,
    RS_NOCHG   = 3'd2,
    RS_CREATED = 3'd3,
    RS_EXITED  = 3'd4,
    RS_FULL    = 3'd5,
    RS_BADSLOT = 3'd6
  } res_status_t;

  typedef enum logic [1:0] {
    SL_FREE = 2'd0,
    SL_NEW  = 2'd1,
    SL_WAIT = 2'd2,
    SL_RUN  = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREV,
    S_WIN,
    S_EXIT,
    S_RESP
  } state_t;

endpackage

@@ rtl/aging_task_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_task_scheduler
// Task-slot scheduler with aging: create, exit and per-core scheduling ticks.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high from the accepting edge
// until the result has been moved into the output register. A tick walks the
// slot table one slot per cycle through a single compare/increment unit; the
// walk stops early at the first slot that has not yet started. A create walks
// the same way up to the first free slot, an exit passes through the exit
// state and an unknown request goes straight to the response state. The block
// returns to the idle state before the next request is taken. The output
// register lets the next request be accepted while a result still waits to be
// transferred. Entry addresses sit in a 16 x 64 memory with a registered read
// port.
// ----------------------------------------------------------------------------
module aging_task_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ats_pkg::FUNC_W-1:0]    in_func,
  input  logic [ats_pkg::CORE_F_W-1:0]  in_core,
  input  logic [ats_pkg::TASK_F_W-1:0]  in_task_slot,
  input  logic [ats_pkg::ENTRY_W-1:0]   in_entry_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ats_pkg::STATUS_W-1:0]  out_status,
  output logic [ats_pkg::TASK_F_W-1:0]  out_chosen_slot,
  output logic [ats_pkg::TASK_F_W-1:0]  out_previous_slot,
  output logic                          out_previous_valid,
  output logic [ats_pkg::ENTRY_W-1:0]   out_start_entry
);
  import ats_pkg::*;

  // Slot table and per-core pointers
  slot_st_t               slot_sts_r [NUM_SLOTS];
  logic [IDLE_BITS-1:0]   idle_r     [NUM_SLOTS];
  logic [CUR_W-1:0]       cur_r      [NUM_CORES];
  logic [ENTRY_W-1:0]     entry_mem  [NUM_SLOTS];
  logic [ENTRY_W-1:0]     ent_rd_r;

  state_t state_r, state_nxt;

  // Latched request
  func_t                  func_r, func_nxt;
  logic [CORE_W-1:0]      core_r, core_nxt;
  logic [TASK_F_W-1:0]    task_r, task_nxt;
  logic                   bad_r, bad_nxt;
  logic [ENTRY_W-1:0]     entry_r, entry_nxt;

  // Scan state
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [IDLE_BITS-1:0]   best_r, best_nxt;
  logic [SLOT_W-1:0]      win_r, win_nxt;
  logic                   win_vld_r, win_vld_nxt;
  logic [SLOT_W-1:0]      prev_r, prev_nxt;
  logic                   prev_vld_r, prev_vld_nxt;

  // Staged result
  res_status_t            res_status_r, res_status_nxt;
  logic [TASK_F_W-1:0]    res_chosen_r, res_chosen_nxt;
  logic [TASK_F_W-1:0]    res_prev_r, res_prev_nxt;
  logic                   res_pvld_r, res_pvld_nxt;
  logic [ENTRY_W-1:0]     res_entry_r, res_entry_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  res_status_t            out_status_r;
  logic [TASK_F_W-1:0]    out_chosen_r, out_prev_r;
  logic                   out_pvld_r;
  logic [ENTRY_W-1:0]     out_entry_r;
  logic                   out_load;

  // Shared read port and unit
  logic [SLOT_W-1:0]      rd_idx;
  slot_st_t               sts_cur;
  logic [IDLE_BITS-1:0]   cnt_cur, cnt_inc;
  logic                   scan_last;
  logic                   cur_vld;

  // Write controls
  logic                   sts_we;
  logic [SLOT_W-1:0]      sts_wa;
  slot_st_t               sts_wd;
  logic                   idle_we;
  logic [SLOT_W-1:0]      idle_wa;
  logic [IDLE_BITS-1:0]   idle_wd;
  logic                   ent_we;
  logic                   cur_we;
  logic                   exit_clr;

  assign sts_cur   = slot_sts_r[rd_idx];
  assign cnt_cur   = idle_r[idx_r];
  assign cnt_inc   = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
  assign scan_last = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign cur_vld   = (int'(cur_r[core_r]) < NUM_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    core_nxt       = core_r;
    task_nxt       = task_r;
    bad_nxt        = bad_r;
    entry_nxt      = entry_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    win_nxt        = win_r;
    win_vld_nxt    = win_vld_r;
    prev_nxt       = prev_r;
    prev_vld_nxt   = prev_vld_r;
    res_status_nxt = res_status_r;
    res_chosen_nxt = res_chosen_r;
    res_prev_nxt   = res_prev_r;
    res_pvld_nxt   = res_pvld_r;
    res_entry_nxt  = res_entry_r;
    in_stall       = 1'b1;
    out_load       = 1'b0;
    rd_idx         = idx_r;
    sts_we         = 1'b0;
    sts_wa         = idx_r;
    sts_wd         = SL_FREE;
    idle_we        = 1'b0;
    idle_wa        = idx_r;
    idle_wd        = '0;
    ent_we         = 1'b0;
    cur_we         = 1'b0;
    exit_clr       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          func_nxt       = func_t'(in_func);
          core_nxt       = CORE_W'(in_core);
          task_nxt       = in_task_slot;
          bad_nxt        = (int'(in_task_slot) >= NUM_SLOTS);
          entry_nxt      = in_entry_address;
          idx_nxt        = '0;
          best_nxt       = '0;
          win_vld_nxt    = 1'b0;
          prev_nxt       = '0;
          prev_vld_nxt   = 1'b0;
          res_status_nxt = RS_NOCHG;
          res_chosen_nxt = '0;
          res_prev_nxt   = '0;
          res_pvld_nxt   = 1'b0;
          res_entry_nxt  = '0;
          unique case (func_t'(in_func))
            F_TICK:   state_nxt = (int'(in_core) < NUM_CORES) ? S_SCAN : S_RESP;
            F_CREATE: state_nxt = S_SCAN;
            F_EXIT:   state_nxt = S_EXIT;
            default:  state_nxt = S_RESP;
          endcase
        end
      end

      S_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (func_r == F_CREATE) begin
          if (sts_cur == SL_FREE) begin
            // claim the lowest free slot
            sts_we         = 1'b1;
            sts_wd         = SL_NEW;
            idle_we        = 1'b1;
            ent_we         = 1'b1;
            res_status_nxt = RS_CREATED;
            res_chosen_nxt = TASK_F_W'(idx_r);
            state_nxt      = S_RESP;
          end else if (scan_last) begin
            res_status_nxt = RS_FULL;
            state_nxt      = S_RESP;
          end
        end else begin
          if (sts_cur == SL_WAIT) begin
            idle_we = 1'b1;
            idle_wd = cnt_inc;
            if (best_r < cnt_inc) begin
              best_nxt    = cnt_inc;
              win_nxt     = idx_r;
              win_vld_nxt = 1'b1;
            end
            if (scan_last) begin
              state_nxt = win_vld_nxt ? S_PREV : S_RESP;
            end
          end else if (sts_cur == SL_NEW) begin
            // a task that never ran wins at once; stop the walk
            win_nxt     = idx_r;
            win_vld_nxt = 1'b1;
            state_nxt   = S_PREV;
          end else if (scan_last) begin
            state_nxt = win_vld_r ? S_PREV : S_RESP;
          end
        end
      end

      S_PREV: begin
        rd_idx = cur_r[core_r][SLOT_W-1:0];
        if (cur_vld && sts_cur != SL_FREE) begin
          sts_we       = 1'b1;
          sts_wa       = rd_idx;
          sts_wd       = SL_WAIT;
          prev_nxt     = rd_idx;
          prev_vld_nxt = 1'b1;
        end
        state_nxt = S_WIN;
      end

      S_WIN: begin
        rd_idx         = win_r;
        sts_we         = 1'b1;
        sts_wa         = win_r;
        sts_wd         = SL_RUN;
        idle_we        = 1'b1;
        idle_wa        = win_r;
        cur_we         = 1'b1;
        res_chosen_nxt = TASK_F_W'(win_r);
        res_prev_nxt   = TASK_F_W'(prev_r);
        res_pvld_nxt   = prev_vld_r;
        if (sts_cur == SL_NEW) begin
          res_status_nxt = RS_FRESH;
          res_entry_nxt  = ent_rd_r;
        end else begin
          res_status_nxt = RS_RESUME;
        end
        state_nxt = S_RESP;
      end

      S_EXIT: begin
        rd_idx         = SLOT_W'(task_r);
        res_chosen_nxt = task_r;
        if (bad_r || sts_cur == SL_FREE) begin
          res_status_nxt = RS_BADSLOT;
        end else begin
          sts_we         = 1'b1;
          sts_wa         = rd_idx;
          sts_wd         = SL_FREE;
          idle_we        = 1'b1;
          idle_wa        = rd_idx;
          exit_clr       = 1'b1;
          res_status_nxt = RS_EXITED;
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // hold until the output register is free or transfers this cycle
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    core_r       <= core_nxt;
    task_r       <= task_nxt;
    bad_r        <= bad_nxt;
    entry_r      <= entry_nxt;
    idx_r        <= idx_nxt;
    best_r       <= best_nxt;
    win_r        <= win_nxt;
    win_vld_r    <= win_vld_nxt;
    prev_r       <= prev_nxt;
    prev_vld_r   <= prev_vld_nxt;
    res_status_r <= res_status_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_prev_r   <= res_prev_nxt;
    res_pvld_r   <= res_pvld_nxt;
    res_entry_r  <= res_entry_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_chosen_r <= res_chosen_r;
      out_prev_r   <= res_prev_r;
      out_pvld_r   <= res_pvld_r;
      out_entry_r  <= res_entry_r;
    end
  end

  // Slot table, idle counts and core pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_sts_r[i] <= SL_FREE;
        idle_r[i]     <= '0;
      end
      for (int c = 0; c < NUM_CORES; c++) begin
        cur_r[c] <= CUR_NONE;
      end
    end else begin
      if (sts_we) begin
        slot_sts_r[sts_wa] <= sts_wd;
      end
      if (idle_we) begin
        idle_r[idle_wa] <= idle_wd;
      end
      if (cur_we) begin
        cur_r[core_r] <= CUR_W'(win_r);
      end
      if (exit_clr) begin
        // drop every core pointer that names the exiting slot
        for (int c = 0; c < NUM_CORES; c++) begin
          if (cur_r[c] == CUR_W'(SLOT_W'(task_r))) begin
            cur_r[c] <= CUR_NONE;
          end
        end
      end
    end
  end

  // Entry address memory, registered read at the winner
  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[idx_r] <= entry_r;
    end
    ent_rd_r <= entry_mem[win_r];
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_chosen_slot    = out_chosen_r;
  assign out_previous_slot  = out_prev_r;
  assign out_previous_valid = out_pvld_r;
  assign out_start_entry    = out_entry_r;

  // Checks
  logic                 cur_ok;
  logic [NUM_SLOTS-1:0] run_vec;

  always_comb begin
    cur_ok = 1'b1;
    for (int c = 0; c < NUM_CORES; c++) begin
      if (int'(cur_r[c]) < NUM_SLOTS &&
          slot_sts_r[cur_r[c][SLOT_W-1:0]] != SL_RUN) begin
        cur_ok = 1'b0;
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      run_vec[i] = (slot_sts_r[i] == SL_RUN);
    end
  end

`ifndef SYNTHESIS
  a_core_points_to_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cur_ok)
    else $error("core pointer names a slot that is not running");

  a_running_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(run_vec) <= NUM_CORES)
    else $error("more running slots than cores");

  a_winner_runnable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WIN |-> (sts_cur == SL_NEW || sts_cur == SL_WAIT))
    else $error("scan winner is neither new nor waiting");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall)
    else $error("request taken while busy");
`endif

endmodule

@@ sim/aging_task_scheduler_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_task_scheduler_test
// Self-checking bench for the aging task scheduler. A behavioral copy of the
// slot table, idle ages, stored entries and per-core pointers predicts every
// answer at the request transfer; each result transfer is checked against the
// oldest prediction. Directed cases come first, then a full-table pass, an
// output hold-off that backs the block up, and random request mixes with and
// without random gaps on both channels.
// ----------------------------------------------------------------------------
module aging_task_scheduler_test;
  import ats_pkg::*;

  localparam int NO_SLOT         = -1;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct {
    res_status_t           status;
    logic [TASK_F_W-1:0]   chosen_slot;
    logic [TASK_F_W-1:0]   previous_slot;
    logic                  previous_valid;
    logic [ENTRY_W-1:0]    start_entry;
  } sched_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FUNC_W-1:0]     in_func = '0;
  logic [CORE_F_W-1:0]   in_core = '0;
  logic [TASK_F_W-1:0]   in_task_slot = '0;
  logic [ENTRY_W-1:0]    in_entry_address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [TASK_F_W-1:0]   out_chosen_slot;
  logic [TASK_F_W-1:0]   out_previous_slot;
  logic                  out_previous_valid;
  logic [ENTRY_W-1:0]    out_start_entry;

  // Behavioral copy of the scheduler state
  slot_st_t              slot_state [NUM_SLOTS];
  logic [IDLE_BITS-1:0]  idle_age   [NUM_SLOTS];
  logic [ENTRY_W-1:0]    entry_mem  [NUM_SLOTS];
  int                    core_task  [NUM_CORES];

  sched_result_t         expected_results [$];
  int                    error_count = 0;
  bit                    tx_idle_on = 1'b0;
  bit                    rx_idle_on = 1'b0;
  bit                    hold_off_req = 1'b0;

  aging_task_scheduler DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_core            (in_core),
    .in_task_slot       (in_task_slot),
    .in_entry_address   (in_entry_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_chosen_slot    (out_chosen_slot),
    .out_previous_slot  (out_previous_slot),
    .out_previous_valid (out_previous_valid),
    .out_start_entry    (out_start_entry)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    foreach (slot_state[i]) begin
      slot_state[i] = SL_FREE;
      idle_age[i]   = '0;
      entry_mem[i]  = '0;
    end
    foreach (core_task[c]) core_task[c] = NO_SLOT;
  end

  // Apply one request to the state copy and return the answer it causes
  function automatic sched_result_t schedule_request(func_t fn,
                                                     logic [CORE_F_W-1:0] core,
                                                     logic [TASK_F_W-1:0] slot,
                                                     logic [ENTRY_W-1:0] entry);
    sched_result_t        r;
    int                   win;
    int                   prior;
    int                   free_slot;
    logic [IDLE_BITS-1:0] best;
    bit                   stop;
    r.status         = RS_NOCHG;
    r.chosen_slot    = '0;
    r.previous_slot  = '0;
    r.previous_valid = 1'b0;
    r.start_entry    = '0;
    case (fn)
      F_TICK: begin
        win  = NO_SLOT;
        best = '0;
        stop = 1'b0;
        if (core < NUM_CORES) begin
          for (int i = 0; i < NUM_SLOTS && !stop; i++) begin
            if (slot_state[i] == SL_WAIT) begin
              if (idle_age[i] != '1) idle_age[i]++;
              if (best < idle_age[i]) begin
                best = idle_age[i];
                win  = i;
              end
            end else if (slot_state[i] == SL_NEW) begin
              // a task not yet started wins at once and ends the scan
              win  = i;
              stop = 1'b1;
            end
          end
        end
        if (win != NO_SLOT) begin
          prior = core_task[core];
          if (prior != NO_SLOT && slot_state[prior] != SL_FREE) slot_state[prior] = SL_WAIT;
          else prior = NO_SLOT;
          core_task[core] = win;
          idle_age[win]   = '0;
          if (slot_state[win] == SL_NEW) begin
            r.status      = RS_FRESH;
            r.start_entry = entry_mem[win];
          end else begin
            r.status = RS_RESUME;
          end
          slot_state[win] = SL_RUN;
          r.chosen_slot   = win[TASK_F_W-1:0];
          if (prior != NO_SLOT) begin
            r.previous_slot  = prior[TASK_F_W-1:0];
            r.previous_valid = 1'b1;
          end
        end
      end
      F_CREATE: begin
        free_slot = NO_SLOT;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
          if (slot_state[i] == SL_FREE) free_slot = i;
        if (free_slot == NO_SLOT) begin
          r.status = RS_FULL;
        end else begin
          slot_state[free_slot] = SL_NEW;
          idle_age[free_slot]   = '0;
          entry_mem[free_slot]  = entry;
          r.status              = RS_CREATED;
          r.chosen_slot         = free_slot[TASK_F_W-1:0];
        end
      end
      F_EXIT: begin
        r.chosen_slot = slot;
        if (slot >= NUM_SLOTS || slot_state[slot] == SL_FREE) begin
          r.status = RS_BADSLOT;
        end else begin
          slot_state[slot] = SL_FREE;
          idle_age[slot]   = '0;
          foreach (core_task[c])
            if (core_task[c] == int'(slot)) core_task[c] = NO_SLOT;
          r.status = RS_EXITED;
        end
      end
      default: r.status = RS_NOCHG;
    endcase
    return r;
  endfunction

  // Predict at each request transfer, check at each result transfer
  always @(posedge clk) begin : check_results
    sched_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting: status %0d slot %0d",
               out_status, out_chosen_slot);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d (%s), actual %0d", exp_r.status,
                 exp_r.status.name(), out_status);
          error_count++;
        end
        if (out_chosen_slot !== exp_r.chosen_slot) begin
          $error("chosen_slot: expected %0d, actual %0d", exp_r.chosen_slot,
                 out_chosen_slot);
          error_count++;
        end
        if (out_previous_slot !== exp_r.previous_slot) begin
          $error("previous_slot: expected %0d, actual %0d", exp_r.previous_slot,
                 out_previous_slot);
          error_count++;
        end
        if (out_previous_valid !== exp_r.previous_valid) begin
          $error("previous_valid: expected %0d, actual %0d", exp_r.previous_valid,
                 out_previous_valid);
          error_count++;
        end
        if (out_start_entry !== exp_r.start_entry) begin
          $error("start_entry: expected %h, actual %h", exp_r.start_entry,
                 out_start_entry);
          error_count++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall)
      expected_results.push_back(schedule_request(func_t'(in_func), in_core,
                                                  in_task_slot, in_entry_address));
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("** aging_task_scheduler: FAILED **");
    $finish;
  end

  // Offer one request and hold it until the transfer
  task automatic send_request(func_t fn, logic [CORE_F_W-1:0] core,
                              logic [TASK_F_W-1:0] slot, logic [ENTRY_W-1:0] entry);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 99) >= 60)
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func          <= fn;
    in_core          <= core;
    in_task_slot     <= slot;
    in_entry_address <= entry;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(F_TICK,   2'd0, 4'd0,  '0);                      // nothing to run
    send_request(F_EXIT,   2'd0, 4'd0,  '0);                      // exit of free slot
    send_request(F_NOP,    2'd3, 4'd15, '1);                      // unknown request
    send_request(F_CREATE, 2'd0, 4'd0,  64'h0);
    send_request(F_CREATE, 2'd1, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    send_request(F_CREATE, 2'd2, 4'd0,  64'hA5A5_A5A5_A5A5_A5A5);
    send_request(F_TICK,   2'd0, 4'd0,  '0);                      // fresh start, slot 0
    send_request(F_TICK,   2'd1, 4'd0,  '0);                      // fresh start, slot 1
    send_request(F_TICK,   2'd0, 4'd0,  '0);                      // switch, previous saved
    send_request(F_TICK,   2'd3, 4'd0,  '0);                      // resume waiting slot
    send_request(F_TICK,   2'd2, 4'd0,  '0);                      // all running
    send_request(F_EXIT,   2'd0, 4'd1,  '0);                      // exit running task
    send_request(F_TICK,   2'd1, 4'd0,  '0);                      // core lost its task
    send_request(F_CREATE, 2'd0, 4'd0,  64'h5A5A_5A5A_5A5A_5A5A); // reuses lowest slot
    send_request(F_CREATE, 2'd0, 4'd0,  64'h8000_0000_0000_0001);
    send_request(F_TICK,   2'd2, 4'd0,  '0);
    send_request(F_TICK,   2'd1, 4'd0,  '0);
    send_request(F_EXIT,   2'd0, 4'd15, '0);                      // highest slot, free
    send_request(F_TICK,   2'd0, 4'd0,  '0);
    send_request(F_TICK,   2'd3, 4'd0,  '0);
    send_request(F_TICK,   2'd0, 4'd0,  '0);                      // all running
    send_request(F_EXIT,   2'd0, 4'd0,  '0);
    send_request(F_TICK,   2'd3, 4'd0,  '0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i <= NUM_SLOTS; i++)
      send_request(F_CREATE, 2'($urandom), 4'($urandom), {$urandom, $urandom});
    for (int c = 0; c < NUM_CORES; c++)
      send_request(F_TICK, c[CORE_F_W-1:0], 4'd0, '0);
    for (int i = 0; i < NUM_SLOTS; i++)
      send_request(F_EXIT, 2'($urandom), i[TASK_F_W-1:0], '0);
  endtask

  // Hold the result side off while requests keep coming
  task automatic test_backlog();
    tx_idle_on   = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_request((i % 2 == 0) ? F_CREATE : F_TICK, 2'($urandom), 4'($urandom),
                   {$urandom, $urandom});
    wait_drain();
  endtask

  task automatic test_random(int count, bit idles);
    int    sel;
    int    busy [$];
    func_t fn;
    logic [TASK_F_W-1:0] slot;
    tx_idle_on = idles;
    rx_idle_on = idles;
    for (int n = 0; n < count; n++) begin
      busy.delete();
      foreach (slot_state[i]) if (slot_state[i] != SL_FREE) busy.push_back(i);
      sel  = $urandom_range(0, 99);
      slot = 4'($urandom);
      if (sel < 4) fn = F_NOP;
      else if (sel < 28 || (busy.size() < 3 && sel < 60)) fn = F_CREATE;
      else if (sel < 50 || (busy.size() > 13 && sel < 70)) fn = F_EXIT;
      else fn = F_TICK;
      // aim most exits at live tasks
      if (fn == F_EXIT && busy.size() > 0 && $urandom_range(0, 9) < 8)
        slot = TASK_F_W'(busy[$urandom_range(0, busy.size() - 1)]);
      send_request(fn, 2'($urandom), slot, {$urandom, $urandom});
    end
  endtask

  initial begin : run_tests
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    test_directed();
    test_table_full();
    test_backlog();
    test_random(200, 1'b1);
    test_random(100, 1'b0);
    test_random(190, 1'b1);
    wait_drain();
    if (error_count == 0) begin
      $display("** aging_task_scheduler: PASSED **");
    end else begin
      $display("** aging_task_scheduler: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ats_pkg.sv
rtl/aging_task_scheduler.sv
sim/aging_task_scheduler_test.sv
